@@ design/transpose_ranking_list_assert.svh @@
// Assertion macros shared by the checker of the transposition ranking list.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef TRANSPOSE_RANKING_LIST_ASSERT_SVH
`define TRANSPOSE_RANKING_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/trl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the transposition ranking list.
// No dependencies; used by the cell, the top level and the checker.
package trl_pkg;

    localparam int CNT_W = 9;
    localparam int PORT_KEY_W = 32;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_CONTAINS = 3'd1,
        OP_GET      = 3'd2,
        OP_DOWN     = 3'd3,
        OP_PEEK     = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_RANGE    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic                  compare;
        logic [PORT_KEY_W-1:0] key;
        logic [CNT_W-1:0]      count;
        logic [CNT_W-1:0]      rank;
        logic                  key_move;
        logic                  get_move;
        logic                  down_move;
        logic                  append;
    } t_cell_cmd;

endpackage

@@ design/transpose_ranking_list.sv @@
`timescale 1ns / 1ps
// Top level of the transposition ranking list: a row of trl_cell slots and
// the command sequencer. Depends on trl_pkg and trl_cell.
//
// An item is taken when start is high and busy is low. In the compare phase,
// busy is high while each cell compares its key and rank; in the apply phase,
// the neighbor swap or append happens and the next item may already be taken.
// The result, registered from the apply phase, appears on o_valid for exactly
// one cycle and must be captured then, since the receiver cannot hold it off.
// The list needs no clearing after reset.
module transpose_ranking_list import trl_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_key,
    input  logic [4:0]  i_rank,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_key_out,
    output logic [4:0]  o_found_rank,
    output logic [4:0]  o_entry_count
);

    localparam int KW = (KEY_BITS < PORT_KEY_W) ? KEY_BITS : PORT_KEY_W;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_APPLY
    } t_phase;

    t_phase        r_phase;
    logic [2:0]    r_op;
    logic [31:0]   r_key;
    logic [4:0]    r_rank;
    logic [CW-1:0] r_count;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [31:0]   r_key_out;
    logic [4:0]    r_found_rank;
    logic [4:0]    r_entry_count;

    logic [KW-1:0]    w_entry [DEPTH];
    logic [DEPTH-1:0] w_khit;
    logic [DEPTH-1:0] w_rhit;
    logic [DEPTH-1:0] w_up;

    t_cell_cmd        cmd;
    logic             accept;
    logic             apply;
    logic             any_hit;
    logic [CNT_W-1:0] found_idx;
    logic [KW-1:0]    key_sel;
    logic [CNT_W-1:0] rank_ext;
    logic [CNT_W-1:0] count_ext;
    logic             rank_ok;
    logic             rank_lt;
    logic             not_full;
    logic             is_key_op;
    logic [1:0]       n_status;
    logic [CW-1:0]    n_count;

    assign accept    = start && !busy;
    assign apply     = (r_phase == PH_APPLY);
    assign rank_ext  = CNT_W'(r_rank);
    assign count_ext = CNT_W'(r_count);
    assign rank_ok   = (r_rank != 5'd0) && (rank_ext <= count_ext);
    assign rank_lt   = rank_ext < count_ext;
    assign not_full  = r_count < CW'(DEPTH);
    assign is_key_op = (r_op == OP_ADD) || (r_op == OP_CONTAINS);

    always_comb begin
        any_hit   = 1'b0;
        found_idx = '0;
        key_sel   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_khit[i]) begin
                any_hit   = 1'b1;
                found_idx = found_idx | CNT_W'(i + 1);
            end
            if (w_rhit[i]) begin
                key_sel = key_sel | w_entry[i];
            end
        end
    end

    always_comb begin
        cmd.compare   = (r_phase == PH_CMP);
        cmd.key       = r_key;
        cmd.count     = count_ext;
        cmd.rank      = rank_ext;
        cmd.key_move  = apply && is_key_op;
        cmd.get_move  = apply && (r_op == OP_GET) && rank_ok;
        cmd.down_move = apply && (r_op == OP_DOWN) && rank_ok && rank_lt;
        cmd.append    = apply && (r_op == OP_ADD) && !any_hit && not_full;
    end

    always_comb begin
        n_count = cmd.append ? r_count + CW'(1) : r_count;
        case (r_op)
            OP_ADD:      n_status = (any_hit || not_full) ? ST_OK : ST_FULL;
            OP_CONTAINS: n_status = any_hit ? ST_OK : ST_NOTFOUND;
            OP_GET,
            OP_DOWN,
            OP_PEEK:     n_status = rank_ok ? ST_OK : ST_RANGE;
            default:     n_status = ST_OK;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KW-1:0] prev_entry;
            logic          prev_rhit;
            logic [KW-1:0] next_entry;
            logic          next_up;

            if (g == 0) begin : g_first
                assign prev_entry = '0;
                assign prev_rhit  = 1'b0;
            end else begin : g_mid
                assign prev_entry = w_entry[g-1];
                assign prev_rhit  = w_rhit[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_entry = '0;
                assign next_up    = 1'b0;
            end else begin : g_inner
                assign next_entry = w_entry[g+1];
                assign next_up    = w_up[g+1];
            end

            trl_cell #(
                .IDX (g),
                .KW  (KW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_prev_entry (prev_entry),
                .i_prev_rhit  (prev_rhit),
                .i_next_entry (next_entry),
                .i_next_up    (next_up),
                .o_entry      (w_entry[g]),
                .o_khit       (w_khit[g]),
                .o_rhit       (w_rhit[g]),
                .o_up         (w_up[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= apply;
            r_count <= n_count;
            case (r_phase)
                PH_IDLE:  r_phase <= start ? PH_CMP : PH_IDLE;
                PH_CMP:   r_phase <= PH_APPLY;
                PH_APPLY: r_phase <= start ? PH_CMP : PH_IDLE;
                default:  r_phase <= PH_IDLE;
            endcase
        end
        if (accept) begin
            r_op   <= i_opcode;
            r_key  <= i_key;
            r_rank <= i_rank;
        end
        if (apply) begin
            r_status      <= n_status;
            r_key_out     <= (((r_op == OP_GET) || (r_op == OP_PEEK)) && rank_ok) ?
                             32'(key_sel) : 32'd0;
            r_found_rank  <= is_key_op ? found_idx[4:0] : 5'd0;
            r_entry_count <= 5'(n_count);
        end
    end

    assign busy          = (r_phase == PH_CMP);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_key_out     = r_key_out;
    assign o_found_rank  = r_found_rank;
    assign o_entry_count = r_entry_count;

endmodule

@@ design/trl_cell.sv @@
`timescale 1ns / 1ps
// One slot of the ranked list: holds a key, latches its compare results,
// and swaps with its neighbors. Depends on trl_pkg.
module trl_cell import trl_pkg::*; #(
    parameter int IDX = 0,
    parameter int KW  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [KW-1:0] i_prev_entry,
    input  logic          i_prev_rhit,
    input  logic [KW-1:0] i_next_entry,
    input  logic          i_next_up,
    output logic [KW-1:0] o_entry,
    output logic          o_khit,
    output logic          o_rhit,
    output logic          o_up
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] RANK_C = CNT_W'(IDX + 1);
    localparam logic             HAS_PREV = (IDX != 0);

    logic [KW-1:0] r_entry;
    logic          r_khit;
    logic          r_rhit;
    logic          n_up;

    always_comb begin
        n_up = HAS_PREV && ((i_cmd.key_move && r_khit) || (i_cmd.get_move && r_rhit) ||
                            (i_cmd.down_move && i_prev_rhit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_khit <= 1'b0;
            r_rhit <= 1'b0;
        end else if (i_cmd.compare) begin
            r_khit <= (IDX_C < i_cmd.count) && (r_entry == i_cmd.key[KW-1:0]);
            r_rhit <= (i_cmd.rank == RANK_C);
        end
        if (n_up) begin
            r_entry <= i_prev_entry;
        end else if (i_next_up) begin
            r_entry <= i_next_entry;
        end else if (i_cmd.append && (i_cmd.count == IDX_C)) begin
            r_entry <= i_cmd.key[KW-1:0];
        end
    end

    assign o_entry = r_entry;
    assign o_khit  = r_khit;
    assign o_rhit  = r_rhit;
    assign o_up    = n_up;

endmodule

@@ design/trl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the transposition ranking list and its bind.
// Depends on trl_pkg and transpose_ranking_list_assert.svh.
`include "transpose_ranking_list_assert.svh"

module trl_checker import trl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_key_out,
    input logic [4:0]  o_found_rank
);

    `TRL_ASSERT_NOW(a_result_timing, 1'b1,
        o_valid == ($past(start && !busy && i_rst_n, 3) && $past(i_rst_n, 2)
                    && $past(i_rst_n, 1)),
        "Result strobe does not follow its item by two cycles")
    `TRL_ASSERT_NEXT(a_busy_single, busy, !busy, "Busy held for more than one cycle")
    `TRL_ASSERT_NOW(a_range_clean, o_valid && (o_status == ST_RANGE),
        (o_key_out == 32'd0) && (o_found_rank == 5'd0),
        "Rank error carries a key or a rank")
    `TRL_ASSERT_NOW(a_miss_clean, o_valid && (o_status == ST_NOTFOUND),
        (o_found_rank == 5'd0) && (o_key_out == 32'd0),
        "Missing key reports a rank or a key")

endmodule

bind transpose_ranking_list trl_checker u_trl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_key_out    (o_key_out),
    .o_found_rank (o_found_rank)
);

@@ tb/transpose_ranking_list_checker.sv @@
`timescale 1ns / 1ps
// Checker for the transposition ranking list: keeps its own copy of the list,
// predicts each result from the accepted items and compares the strobed results.
// Depends on trl_pkg for the opcode and status codes.
module transpose_ranking_list_checker import trl_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_key,
    input  logic [4:0]  i_rank,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [31:0] o_key_out,
    input  logic [4:0]  o_found_rank,
    input  logic [4:0]  o_entry_count,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        t_status     status;
        logic [31:0] key_out;
        logic [4:0]  found_rank;
        logic [4:0]  entry_count;
    } rank_result_t;

    logic [31:0]  list_keys [DEPTH];
    int unsigned  list_len;
    rank_result_t expected_q [$];
    rank_result_t want;

    function automatic int unsigned locate_key(input logic [31:0] k);
        for (int i = 0; i < list_len; i++) begin
            if (list_keys[i] == k) return i + 1;
        end
        return 0;
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic [31:0] t;
        t            = list_keys[a];
        list_keys[a] = list_keys[b];
        list_keys[b] = t;
    endfunction

    function automatic rank_result_t apply_item(input logic [2:0] op, input logic [31:0] k,
                                                input logic [4:0] r);
        rank_result_t res;
        int unsigned  hit;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD: begin
                hit            = locate_key(k);
                res.found_rank = hit[4:0];
                if (hit > 1) begin
                    swap_slots(hit - 1, hit - 2);
                end else if (hit == 0) begin
                    if (list_len < DEPTH) begin
                        list_keys[list_len] = k;
                        list_len++;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            end
            OP_CONTAINS: begin
                hit            = locate_key(k);
                res.found_rank = hit[4:0];
                if (hit == 0) begin
                    res.status = ST_NOTFOUND;
                end else if (hit > 1) begin
                    swap_slots(hit - 1, hit - 2);
                end
            end
            OP_GET, OP_DOWN, OP_PEEK: begin
                if (r == 0 || r > list_len) begin
                    res.status = ST_RANGE;
                end else if (op == OP_GET) begin
                    res.key_out = list_keys[r - 1];
                    if (r > 1) swap_slots(r - 1, r - 2);
                end else if (op == OP_DOWN) begin
                    if (r < list_len) swap_slots(r - 1, r);
                end else begin
                    res.key_out = list_keys[r - 1];
                end
            end
            default: begin
            end
        endcase
        res.entry_count = list_len[4:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        if (fail_count < 100) begin
            $display("%0t ranking list mismatch: %s got %0h expected %0h",
                     $time, what, got, exp);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            for (int i = 0; i < DEPTH; i++) list_keys[i] = '0;
            expected_q.delete();
        end else begin
            if (start && !busy) begin
                expected_q.push_back(apply_item(i_opcode, i_key, i_rank));
            end
            if (o_valid === 1'b1) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no item pending", 32'(o_status), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_key_out !== want.key_out)
                        report_mismatch("key_out", o_key_out, want.key_out);
                    if (o_found_rank !== want.found_rank)
                        report_mismatch("found_rank", 32'(o_found_rank),
                                        32'(want.found_rank));
                    if (o_entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(o_entry_count),
                                        32'(want.entry_count));
                end
            end
        end
        pending_count = expected_q.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the transposition ranking list: clock, reset, directed and
// random items with idle bursts. Depends on trl_pkg, the block and its checker.
module tb import trl_pkg::*;;

    localparam int          LIST_DEPTH  = 16;
    localparam int          RAND_ITEMS  = 550;
    localparam int          POOL_SIZE   = 24;
    localparam logic [2:0]  OP_SPARE_LO = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_key    = '0;
    logic [4:0]  i_rank   = '0;
    logic        busy;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_key_out;
    logic [4:0]  o_found_rank;
    logic [4:0]  o_entry_count;
    int          fail_count;
    int          pending_count;

    logic [31:0] key_pool [POOL_SIZE];

    transpose_ranking_list #(
        .DEPTH    (LIST_DEPTH),
        .KEY_BITS (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_rank        (i_rank),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_found_rank  (o_found_rank),
        .o_entry_count (o_entry_count)
    );

    transpose_ranking_list_checker #(
        .DEPTH (LIST_DEPTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_rank        (i_rank),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_found_rank  (o_found_rank),
        .o_entry_count (o_entry_count),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_item(input logic [2:0] op, input logic [31:0] k, input logic [4:0] r);
        bit taken;
        start    <= 1'b1;
        i_opcode <= op;
        i_key    <= k;
        i_rank   <= r;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        logic [2:0]  op;
        logic [31:0] k;
        logic [4:0]  r;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_CONTAINS, 32'h1234_5678, 5'd0);
        send_item(OP_GET, 32'h0, 5'd0);
        send_item(OP_PEEK, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_DOWN, 32'h0, 5'd1);
        send_item(OP_SPARE_LO, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_SPARE_HI, 32'h0, 5'd1);
        send_item(OP_ADD, 32'h0000_0000, 5'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_ADD, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_CONTAINS, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_CONTAINS, 32'h0000_0000, 5'd0);
        send_item(OP_GET, 32'h0, 5'd2);
        send_item(OP_GET, 32'h0, 5'd1);
        send_item(OP_DOWN, 32'h0, 5'd1);
        send_item(OP_DOWN, 32'h0, 5'd2);
        send_item(OP_PEEK, 32'h0, 5'd2);
        send_item(OP_PEEK, 32'h0, 5'd3);
        send_item(OP_SPARE_LO + 3'd1, 32'hA5A5_5A5A, 5'd17);
        wait_results_drained();

        // The list only grows, so adds are kept rare enough that many items
        // see a partly filled list before it saturates.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom;
            if (pick < 18) begin
                op = OP_ADD;
                if ($urandom_range(0, 9) != 0) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 38) begin
                op = OP_CONTAINS;
                if ($urandom_range(0, 4) != 0) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 55) begin
                op = OP_GET;
            end else if (pick < 72) begin
                op = OP_DOWN;
            end else if (pick < 94) begin
                op = OP_PEEK;
            end else begin
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            pick = $urandom_range(0, 19);
            if (pick < 17) r = 5'($urandom_range(1, LIST_DEPTH));
            else if (pick < 19) r = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'(LIST_DEPTH + 1);
            else r = 5'($urandom_range(0, 31));
            send_item(op, k, r);
            if (n == RAND_ITEMS / 2) begin
                wait_results_drained();
            end else if (n < RAND_ITEMS - 60 && (n / 50) % 3 != 2
                         && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 10));
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
